// ===== design/tlvf_pkg.sv =====
// tlvf_pkg: types and constants shared by the TLV record finder modules.
// No dependencies.
package tlvf_pkg;

   localparam int unsigned MAX_VALUE_LEN = 63;

   localparam logic [7:0] WANTED_TYPE_RESET = 8'd2;

   localparam logic [2:0] ST_BUSY       = 3'd0;
   localparam logic [2:0] ST_FOUND      = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
   localparam logic [2:0] ST_BAD_HEADER = 3'd3;
   localparam logic [2:0] ST_TRUNCATED  = 3'd4;

   localparam logic [2:0] HDR_LEN_HIGH = 3'd4;
   localparam logic [2:0] HDR_LEN_LOW  = 3'd5;

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_HEADER = 7'b0000010,
      PH_TYPE   = 7'b0000100,
      PH_LEN    = 7'b0001000,
      PH_VALUE  = 7'b0010000,
      PH_SKIP   = 7'b0100000,
      PH_DONE   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] value_byte;
      logic       has_data;
      logic [2:0] status;
      logic       last;
   } result_type;

endpackage

// ===== design/tlvf_parser.sv =====
// tlvf_parser: per-byte header and record walk state with its next-state step.
// Produces at most one result per processed byte. Depends on tlvf_pkg.
module tlvf_parser import tlvf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       start_req,
   input  logic [7:0] wanted_type,
   output result_type result
);

   phase_type  phase_ff, phase_in;
   logic [2:0] header_count_ff, header_count_in;
   logic [7:0] length_high_ff, length_high_in;
   logic [7:0] area_length_ff, area_length_in;
   logic [7:0] area_position_ff, area_position_in;
   logic [7:0] record_remaining_ff, record_remaining_in;
   logic       record_matched_ff, record_matched_in;

   phase_type  ph;
   logic [2:0] hc;
   logic [7:0] lh;
   logic [7:0] alen;
   logic [7:0] pos;
   logic [7:0] rem;
   logic       matched;
   logic [7:0] pos_inc;
   logic [7:0] rem_dec;
   logic       area_end;

   always_comb begin
      ph      = start_req ? PH_HEADER : phase_ff;
      hc      = start_req ? 3'd0 : header_count_ff;
      lh      = start_req ? 8'd0 : length_high_ff;
      alen    = start_req ? 8'd0 : area_length_ff;
      pos     = start_req ? 8'd0 : area_position_ff;
      rem     = start_req ? 8'd0 : record_remaining_ff;
      matched = start_req ? 1'b0 : record_matched_ff;

      pos_inc  = pos + 8'd1;
      rem_dec  = rem - 8'd1;
      area_end = (pos_inc >= alen);

      phase_in            = ph;
      header_count_in     = hc;
      length_high_in      = lh;
      area_length_in      = alen;
      area_position_in    = pos;
      record_remaining_in = rem;
      record_matched_in   = matched;
      result              = '0;

      unique case (ph)
         PH_HEADER: begin
            if (hc == HDR_LEN_HIGH) begin
               length_high_in = data_byte;
            end
            if (hc == HDR_LEN_LOW) begin
               if ((lh != 8'd0) || (data_byte == 8'd0)) begin
                  result.emit   = 1'b1;
                  result.status = ST_BAD_HEADER;
                  result.last   = 1'b1;
               end else begin
                  area_length_in   = data_byte;
                  area_position_in = 8'd0;
                  phase_in         = PH_TYPE;
               end
            end else begin
               header_count_in = hc + 3'd1;
            end
         end
         PH_TYPE: begin
            record_matched_in = (data_byte == wanted_type);
            area_position_in  = pos_inc;
            if (area_end) begin
               result.emit   = 1'b1;
               result.status = ST_NOT_FOUND;
               result.last   = 1'b1;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            area_position_in = pos_inc;
            if (matched && (data_byte <= 8'(MAX_VALUE_LEN))) begin
               if (data_byte == 8'd0) begin
                  result.emit   = 1'b1;
                  result.status = ST_FOUND;
                  result.last   = 1'b1;
               end else if (data_byte > (alen - pos_inc)) begin
                  result.emit   = 1'b1;
                  result.status = ST_TRUNCATED;
                  result.last   = 1'b1;
               end else begin
                  record_remaining_in = data_byte;
                  phase_in            = PH_VALUE;
               end
            end else begin
               record_matched_in   = 1'b0;
               record_remaining_in = data_byte;
               if (area_end) begin
                  result.emit   = 1'b1;
                  result.status = ST_NOT_FOUND;
                  result.last   = 1'b1;
               end else begin
                  phase_in = (data_byte == 8'd0) ? PH_TYPE : PH_SKIP;
               end
            end
         end
         PH_VALUE: begin
            area_position_in    = pos_inc;
            record_remaining_in = rem_dec;
            result.emit         = 1'b1;
            result.value_byte   = data_byte;
            result.has_data     = 1'b1;
            if (rem_dec == 8'd0) begin
               result.status = ST_FOUND;
               result.last   = 1'b1;
            end else begin
               result.status = ST_BUSY;
            end
         end
         PH_SKIP: begin
            area_position_in    = pos_inc;
            record_remaining_in = rem_dec;
            if (area_end) begin
               result.emit   = 1'b1;
               result.status = ST_NOT_FOUND;
               result.last   = 1'b1;
            end else if (rem_dec == 8'd0) begin
               phase_in = PH_TYPE;
            end
         end
         PH_IDLE, PH_DONE: begin
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (result.last) begin
         phase_in = PH_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         header_count_ff     <= 3'd0;
         length_high_ff      <= 8'd0;
         area_length_ff      <= 8'd0;
         area_position_ff    <= 8'd0;
         record_remaining_ff <= 8'd0;
         record_matched_ff   <= 1'b0;
      end else if (step) begin
         phase_ff            <= phase_in;
         header_count_ff     <= header_count_in;
         length_high_ff      <= length_high_in;
         area_length_ff      <= area_length_in;
         area_position_ff    <= area_position_in;
         record_remaining_ff <= record_remaining_in;
         record_matched_ff   <= record_matched_in;
      end
   end

endmodule

// ===== design/tlv_record_finder.sv =====
// tlv_record_finder: finds the first matching TLV record in an EEPROM image byte stream.
// Input transfer to result transfer: input register, per-byte parse step, result register.
// Throughput: one byte per cycle while the result output is not stalled (rsp_stall).
// Reset: synchronous, active high; clears the parse state to idle, empties both registers
// and sets the wanted type to 2. Depends on tlvf_pkg and tlvf_parser.
module tlv_record_finder import tlvf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_start_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_value_byte,
   output logic       rsp_has_data,
   output logic [2:0] rsp_status,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic [7:0] wanted_type_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       advance;
   logic       step;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = advance ? (step && result.emit) : rsp_valid_ff;

   tlvf_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .start_req   (in_start_ff),
      .wanted_type (wanted_type_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         wanted_type_ff <= WANTED_TYPE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            wanted_type_ff <= csr_write_data;
         end
      end
   end

   // hold payloads until the next transfer
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_start_req;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_byte = rsp_ff.value_byte;
   assign rsp_has_data   = rsp_ff.has_data;
   assign rsp_status     = rsp_ff.status;
   assign rsp_last       = rsp_ff.last;

   a_data_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_data |-> (rsp_status == ST_BUSY || rsp_status == ST_FOUND))
      else $error("data result with a final error status");

   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_status == ST_BUSY && rsp_has_data))
      else $error("non-final result without data or with a final status");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled with an empty input register");

   a_step_advances: assert property (@(posedge clock) disable iff (reset)
      step && result.emit |=> rsp_valid)
      else $error("result of a processed byte lost");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for tlv_record_finder: EEPROM images go in one byte per transfer,
// a scoreboard class predicts every result and compares it field by field.
// Depends on tlvf_pkg and the tlv_record_finder RTL.
module testbench;
   import tlvf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS = 375;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       has_data;
      logic [2:0] status;
      logic       last;
   } search_result;

   typedef struct {
      logic [7:0] data_byte;
      logic       start_req;
   } image_byte;

   class record_search_tracker;
      logic [7:0]   wanted_type = WANTED_TYPE_RESET;
      phase_type    parse_phase = PH_IDLE;
      logic [2:0]   header_count = '0;
      logic [7:0]   length_high = '0;
      logic [7:0]   area_length = '0;
      logic [7:0]   area_position = '0;
      logic [7:0]   record_remaining = '0;
      logic         record_matched = 1'b0;
      search_result pending_results[$];
      int           errors = 0;

      function void set_wanted_type(logic [7:0] code);
         wanted_type = code;
      endfunction

      function void add_result(logic [7:0] value, logic has_data, logic [2:0] status,
                               logic last);
         search_result r;
         r.value_byte = has_data ? value : 8'h00;
         r.has_data = has_data;
         r.status = status;
         r.last = last;
         pending_results.push_back(r);
         if (last)
            parse_phase = PH_DONE;
      endfunction

      function void take_byte(logic [7:0] b, logic start);
         if (start) begin
            parse_phase = PH_HEADER;
            header_count = '0;
            length_high = '0;
            area_length = '0;
            area_position = '0;
            record_remaining = '0;
            record_matched = 1'b0;
         end
         case (parse_phase)
            PH_HEADER: begin
               if (header_count == HDR_LEN_HIGH)
                  length_high = b;
               if (header_count == HDR_LEN_LOW) begin
                  if (length_high != 0 || b == 0) begin
                     add_result(8'h00, 1'b0, ST_BAD_HEADER, 1'b1);
                  end else begin
                     area_length = b;
                     area_position = '0;
                     parse_phase = PH_TYPE;
                  end
               end else begin
                  header_count = header_count + 3'd1;
               end
            end
            PH_TYPE: begin
               record_matched = (b == wanted_type);
               area_position = area_position + 8'd1;
               if (area_position >= area_length)
                  add_result(8'h00, 1'b0, ST_NOT_FOUND, 1'b1);
               else
                  parse_phase = PH_LEN;
            end
            PH_LEN: begin
               area_position = area_position + 8'd1;
               if (record_matched && b <= MAX_VALUE_LEN) begin
                  if (b == 0) begin
                     add_result(8'h00, 1'b0, ST_FOUND, 1'b1);
                  end else if (b > area_length - area_position) begin
                     add_result(8'h00, 1'b0, ST_TRUNCATED, 1'b1);
                  end else begin
                     record_remaining = b;
                     parse_phase = PH_VALUE;
                  end
               end else begin
                  record_matched = 1'b0;
                  record_remaining = b;
                  if (area_position >= area_length)
                     add_result(8'h00, 1'b0, ST_NOT_FOUND, 1'b1);
                  else
                     parse_phase = (b == 0) ? PH_TYPE : PH_SKIP;
               end
            end
            PH_VALUE: begin
               area_position = area_position + 8'd1;
               record_remaining = record_remaining - 8'd1;
               if (record_remaining == 0)
                  add_result(b, 1'b1, ST_FOUND, 1'b1);
               else
                  add_result(b, 1'b1, ST_BUSY, 1'b0);
            end
            PH_SKIP: begin
               area_position = area_position + 8'd1;
               record_remaining = record_remaining - 8'd1;
               if (area_position >= area_length)
                  add_result(8'h00, 1'b0, ST_NOT_FOUND, 1'b1);
               else if (record_remaining == 0)
                  parse_phase = PH_TYPE;
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(search_result got);
         search_result exp;
         if (pending_results.size() == 0) begin
            $error("unexpected result: value_byte %0h has_data %0d status %0d last %0d",
                   got.value_byte, got.has_data, got.status, got.last);
            errors++;
            return;
         end
         exp = pending_results.pop_front();
         if (got.value_byte !== exp.value_byte) begin
            $error("value_byte: expected %0h, got %0h", exp.value_byte, got.value_byte);
            errors++;
         end
         if (got.has_data !== exp.has_data) begin
            $error("has_data: expected %0d, got %0d", exp.has_data, got.has_data);
            errors++;
         end
         if (got.status !== exp.status) begin
            $error("status mismatch: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_start_req = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_value_byte;
   logic       rsp_has_data;
   logic [2:0] rsp_status;
   logic       rsp_last;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   logic       calm = 1'b0;
   int         hold_requests = 0;
   int         holds_done = 0;
   int         hold_left = 0;
   int         cycle_count = 0;
   int         items_sent = 0;
   logic [7:0] wanted_now = WANTED_TYPE_RESET;
   image_byte  stim_q[$];

   record_search_tracker tracker = new();

   tlv_record_finder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_start_req    (req_start_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_has_data     (rsp_has_data),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (holds_done != hold_requests) begin
         holds_done = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 35);
      end
   end

   always @(negedge clock) begin
      search_result seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.value_byte = rsp_value_byte;
         seen.has_data = rsp_has_data;
         seen.status = rsp_status;
         seen.last = rsp_last;
         tracker.check_result(seen);
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic s);
      image_byte item;
      item.data_byte = b;
      item.start_req = s;
      stim_q.push_back(item);
   endtask

   task automatic queue_header(input logic [7:0] fill, input logic [7:0] len_high,
                               input logic [7:0] len_low);
      queue_byte(fill, 1'b1);
      repeat (3) queue_byte(fill, 1'b0);
      queue_byte(len_high, 1'b0);
      queue_byte(len_low, 1'b0);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic s);
      while (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_start_req <= s;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      tracker.take_byte(b, s);
      items_sent++;
   endtask

   task automatic play_stimulus();
      image_byte item;
      while (stim_q.size() != 0) begin
         item = stim_q.pop_front();
         send_byte(item.data_byte, item.start_req);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_wanted_type(input logic [7:0] code);
      csr_write_enable <= 1'b1;
      csr_write_data <= code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_wanted_type(code);
      wanted_now = code;
   endtask

   task automatic queue_random_image(input logic [7:0] want);
      int roll;
      int area;
      int left;
      int len;
      int n;
      roll = $urandom_range(99);
      if (roll < 5) begin
         n = $urandom_range(6, 1);
         repeat (n) queue_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
         return;
      end
      if (roll < 10) begin
         queue_header(8'($urandom_range(255)), 8'($urandom_range(255, 1)),
                      8'($urandom_range(255)));
      end else if (roll < 14) begin
         queue_header(8'($urandom_range(255)), 8'h00, 8'h00);
      end else begin
         roll = $urandom_range(99);
         if (roll < 70)
            area = $urandom_range(20, 1);
         else if (roll < 92)
            area = $urandom_range(90, 21);
         else
            area = $urandom_range(255, 91);
         queue_header(8'($urandom_range(255)), 8'h00, 8'(area));
         left = area;
         while (left > 0) begin
            queue_byte(($urandom_range(99) < 35) ? want : 8'($urandom_range(255)), 1'b0);
            left--;
            if (left == 0)
               break;
            left--;
            roll = $urandom_range(99);
            if (roll < 10)
               len = 0;
            else if (roll < 65)
               len = $urandom_range(8, 1);
            else if (roll < 78)
               len = $urandom_range(MAX_VALUE_LEN + 3, MAX_VALUE_LEN - 2);
            else if (roll < 88)
               len = $urandom_range(255);
            else
               len = left + $urandom_range(3, 1);
            if (len > 255)
               len = 255;
            queue_byte(8'(len), 1'b0);
            n = (len < left) ? len : left;
            repeat (n) queue_byte(8'($urandom_range(255)), 1'b0);
            left -= n;
         end
      end
      if ($urandom_range(99) < 8) begin
         n = $urandom_range(stim_q.size() - 1, 1);
         while (stim_q.size() > n) void'(stim_q.pop_back());
      end
      if ($urandom_range(99) < 30)
         repeat ($urandom_range(3, 1)) queue_byte(8'($urandom_range(255)), 1'b0);
   endtask

   initial begin
      int phase_goal;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_byte(8'h00, 1'b0);
      queue_header(8'hFF, 8'hFF, 8'hFF);
      queue_byte(8'hA5, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_header(8'h00, 8'h00, 8'h00);
      queue_byte(8'h5A, 1'b0);
      queue_header(8'h11, 8'h00, 8'd2);
      queue_byte(wanted_now, 1'b0);
      queue_byte(8'd0, 1'b0);
      queue_header(8'h22, 8'h00, 8'd4);
      queue_byte(wanted_now, 1'b0);
      queue_byte(8'd3, 1'b0);
      queue_header(8'h33, 8'h00, 8'd3);
      queue_byte(wanted_now, 1'b0);
      queue_byte(8'(MAX_VALUE_LEN + 1), 1'b0);
      queue_byte(8'h77, 1'b0);
      queue_header(8'h44, 8'h00, 8'd3);
      queue_byte(wanted_now, 1'b0);
      queue_byte(8'd1, 1'b0);
      queue_byte(8'h7E, 1'b0);
      queue_header(8'h55, 8'h00, 8'd1);
      queue_byte(8'h00, 1'b0);
      play_stimulus();

      for (int p = 0; p < 4; p++) begin
         wait_idle();
         case (p)
            0: write_wanted_type(8'h00);
            1: write_wanted_type(8'hFF);
            2: write_wanted_type(8'($urandom_range(254, 1)));
            default: write_wanted_type(WANTED_TYPE_RESET);
         endcase
         if (p == 2)
            calm <= 1'b1;
         if (p == 1) begin
            hold_requests <= hold_requests + 1;
            queue_header(8'($urandom_range(255)), 8'h00, 8'd60);
            queue_byte(wanted_now, 1'b0);
            queue_byte(8'd55, 1'b0);
            repeat (55) queue_byte(8'($urandom_range(255)), 1'b0);
            play_stimulus();
         end
         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal) begin
            queue_random_image(wanted_now);
            play_stimulus();
         end
         if (p == 2)
            calm <= 1'b0;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tlvf_pkg.sv
design/tlvf_parser.sv
design/tlv_record_finder.sv
tb/sv/testbench.sv
